### rtl/core/assert_macros.svh
// assertion macros used by the top level of the positional list
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

### rtl/core/pol_pkg.sv
// types and codes shared by the positional list modules
`timescale 1ns / 1ps

package pol_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DUMP      = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic op_go;
        logic dump_step;
        logic dump_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
    } t_dp_stat;

endpackage

### rtl/core/pol_dpath.sv
// datapath: shifting cell row, element count and result register
`timescale 1ns / 1ps

module pol_dpath import pol_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    localparam int UW = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  logic [2:0]    i_opcode,
    input  logic [31:0]   i_value,
    input  logic [4:0]    i_position,
    output t_dp_stat      o_stat,
    output logic [UW-1:0] o_used,
    output logic [1:0]    o_status,
    output logic [31:0]   o_element,
    output logic [4:0]    o_count,
    output logic          o_last
);

    localparam int CW = ((UW > 5) ? UW : 5) + 1;

    logic [DATA_WIDTH-1:0] r_cells [CAPACITY];
    logic [DATA_WIDTH-1:0] n_cells [CAPACITY];
    logic [DATA_WIDTH-1:0] prev_c  [CAPACITY];
    logic [DATA_WIDTH-1:0] next_c  [CAPACITY];
    logic [UW-1:0]         r_used, n_used;
    logic [1:0]            r_status;
    logic [31:0]           r_element;
    logic [4:0]            r_count;
    logic                  r_last;

    logic [63:0]           val_w, head_w;
    logic [DATA_WIDTH-1:0] val_d;
    logic [CW-1:0]         pos_c, used_c, idx, cnt_w;
    logic                  full, empty, do_ins, do_del;
    t_status               op_st;

    assign val_w  = 64'(i_value);
    assign val_d  = val_w[DATA_WIDTH-1:0];
    assign head_w = 64'(r_cells[0]);
    assign pos_c  = CW'(i_position);
    assign used_c = CW'(r_used);
    assign full   = (used_c == CW'(CAPACITY));
    assign empty  = (r_used == '0);

    // neighbor taps of each cell
    for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
        if (g == 0) begin : g_first
            assign prev_c[g] = val_d;
        end else begin : g_rest
            assign prev_c[g] = r_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_lastc
            assign next_c[g] = r_cells[g];
        end else begin : g_inner
            assign next_c[g] = r_cells[g+1];
        end
    end

    // operation decode and checks
    always_comb begin
        op_st  = ST_OK;
        do_ins = 1'b0;
        do_del = 1'b0;
        idx    = '0;
        case (i_opcode)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (full) begin
                    op_st = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    idx    = (i_opcode == OP_INS_FRONT) ? '0 : used_c;
                end
            end
            OP_INS_AT: begin
                if (pos_c == '0 || pos_c > used_c + CW'(1)) begin
                    op_st = ST_BADPOS;
                end else if (full) begin
                    op_st = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    idx    = pos_c - CW'(1);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
                if (empty) begin
                    op_st = ST_EMPTY;
                end else begin
                    do_del = 1'b1;
                    idx    = (i_opcode == OP_DEL_FRONT) ? '0 : used_c - CW'(1);
                end
            end
            OP_DEL_AT: begin
                if (empty) begin
                    op_st = ST_EMPTY;
                end else if (pos_c == '0 || pos_c > used_c) begin
                    op_st = ST_BADPOS;
                end else begin
                    do_del = 1'b1;
                    idx    = pos_c - CW'(1);
                end
            end
            OP_DUMP: begin
                if (empty) begin
                    op_st = ST_EMPTY;
                end
            end
            default: begin
                op_st = ST_OK;
            end
        endcase
    end

    // every cell picks itself, a neighbor, the new value or the head
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
            if (i_cmd.op_go && do_ins) begin
                if (CW'(i) == idx) begin
                    n_cells[i] = val_d;
                end else if (CW'(i) > idx) begin
                    n_cells[i] = prev_c[i];
                end
            end else if (i_cmd.op_go && do_del) begin
                if (CW'(i) >= idx) begin
                    n_cells[i] = next_c[i];
                end
            end else if (i_cmd.dump_step) begin
                n_cells[i] = (CW'(i + 1) == used_c) ? r_cells[0] : next_c[i];
            end
        end
    end

    always_comb begin
        n_used = r_used;
        if (i_cmd.op_go && do_ins) begin
            n_used = r_used + UW'(1);
        end else if (i_cmd.op_go && do_del) begin
            n_used = r_used - UW'(1);
        end
    end

    assign cnt_w = CW'(n_used);

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op_go) begin
            r_status  <= op_st;
            r_element <= '0;
            r_count   <= cnt_w[4:0];
            r_last    <= 1'b1;
        end else if (i_cmd.dump_step) begin
            r_status  <= ST_OK;
            r_element <= head_w[31:0];
            r_count   <= cnt_w[4:0];
            r_last    <= i_cmd.dump_last;
        end
    end

    assign o_stat.empty = empty;
    assign o_used       = r_used;
    assign o_status     = r_status;
    assign o_element    = r_element;
    assign o_count      = r_count;
    assign o_last       = r_last;

endmodule

### rtl/core/pol_ctrl.sv
// controller: handshakes, dump sequencing and result valid
`timescale 1ns / 1ps

module pol_ctrl import pol_pkg::*; #(
    parameter int CAPACITY = 16,
    localparam int UW = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_opcode,
    input  t_dp_stat      i_stat,
    input  logic [UW-1:0] i_used,
    output t_dp_cmd       o_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready
);

    t_state        r_state, n_state;
    logic [UW-1:0] r_left, n_left;
    logic          r_out_valid, n_out_valid;
    logic          out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    if (i_opcode == OP_DUMP && !i_stat.empty) begin
                        n_state = S_DUMP;
                        n_left  = i_used;
                    end else begin
                        o_cmd.op_go = 1'b1;
                    end
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    o_cmd.dump_step = 1'b1;
                    o_cmd.dump_last = (r_left == UW'(1));
                    n_left          = r_left - UW'(1);
                    if (r_left == UW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.op_go || o_cmd.dump_step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/positional_ordered_list.sv
// top level of the bounded positional list
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Bounded ordered list of up to CAPACITY values. Each input item is one
// operation: insert at front, back or a 1-based position; delete at front,
// back or a position; or dump. Every operation other than dump returns one
// result item with a status (ok, invalid position, empty, full) and the count
// after the operation, with element zero and last set. A dump streams the
// held elements front to back, marking the final one with last; a dump of an
// empty list returns one item with the empty status. Inserts and deletes
// shift all cells in parallel. A dump first enters the dump sequence, then
// emits one element per step, each read from the single head tap that the
// cell row rotates past; a step waits while the output is held. The
// result sits in an output register, so a new item is accepted while the
// previous result waits, as long as the consumer drains it. Cells hold no
// reset value; only entries below the count are ever shown.
module positional_ordered_list import pol_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // operation item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_value,
    input  logic [4:0]  i_position,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_element,
    output logic [4:0]  o_count,
    output logic        o_last
);

    localparam int UW = $clog2(CAPACITY + 1);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [UW-1:0] used;

    // sequencing: accept, dump stepping, output valid
    pol_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_stat      (stat),
        .i_used      (used),
        .o_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    // cell row, count and result payload
    pol_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .i_position (i_position),
        .o_stat     (stat),
        .o_used     (used),
        .o_status   (o_status),
        .o_element  (o_element),
        .o_count    (o_count),
        .o_last     (o_last)
    );

    // count never runs past the cell row
    `ASSERT_CLK(a_used_bound, i_clk, i_rst_n, used <= UW'(CAPACITY), "count over capacity")
    // a single operation and a dump step never share a cycle
    `ASSERT_NEVER(a_cmd_excl, i_clk, i_rst_n, cmd.op_go && cmd.dump_step, "op with dump step")
    // input is held off while a dump streams
    `ASSERT_NEVER(a_dump_hold, i_clk, i_rst_n, cmd.dump_step && o_in_ready, "ready during dump")
    // a plain operation leaves one final result
    `ASSERT_CLK(a_op_result, i_clk, i_rst_n, cmd.op_go |=> o_out_valid && o_last, "no op result")
    // only dump items carry a non-final result, always with ok status
    `ASSERT_CLK(a_mid, i_clk, i_rst_n, o_out_valid && !o_last |-> o_status == ST_OK, "dump status")

endmodule
